// ===== src/slid_pkg.sv =====
package slid_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int VAL_W    = 32;
   localparam int CMD_W    = 2;
   localparam int STAT_W   = 3;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

   localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STAT_W-1:0] ST_DELETED   = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] ST_ENTRY     = 3'd4;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd5;

   // controller to datapath
   typedef struct packed {
      logic              do_insert;
      logic              do_delete;
      logic              load_out;
      logic [STAT_W-1:0] out_status;
      logic              out_from_cell;
      logic              out_zero;
      logic              out_last;
      logic [IDX_W-1:0]  rd_idx;
   } slid_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic             full;
      logic             empty;
      logic             found;
      logic [CNT_W-1:0] count;
      logic [IDX_W-1:0] last_idx;
   } slid_sts_type;

endpackage

// ===== src/slid_req_if.sv =====
interface slid_req_if;
   logic                                valid;
   logic                                ready;
   logic [slid_pkg::CMD_W-1:0]          cmd;
   logic signed [slid_pkg::VAL_W-1:0]   value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== src/slid_rsp_if.sv =====
interface slid_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [slid_pkg::STAT_W-1:0]         status;
   logic signed [slid_pkg::VAL_W-1:0]   item_value;
   logic                                last;

   modport source (output valid, output status, output item_value, output last, input ready);
   modport sink   (input valid, input status, input item_value, input last, output ready);
endinterface

// ===== src/slid_ctrl.sv =====
module slid_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [slid_pkg::CMD_W-1:0]      req_cmd,
   output logic                            req_ready,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   input  slid_pkg::slid_sts_type          dp_sts,
   output slid_pkg::slid_cmd_type          dp_cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic                        state_ff, state_in;
   logic [slid_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                        valid_ff, valid_in;
   logic                        out_free;
   logic                        accept;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      dp_cmd   = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  slid_pkg::CMD_INSERT: begin
                     dp_cmd.do_insert  = !dp_sts.full;
                     dp_cmd.load_out   = 1'b1;
                     dp_cmd.out_status = dp_sts.full ? slid_pkg::ST_FULL
                                                     : slid_pkg::ST_INSERTED;
                     dp_cmd.out_last   = 1'b1;
                  end
                  slid_pkg::CMD_DELETE: begin
                     dp_cmd.do_delete  = 1'b1;
                     dp_cmd.load_out   = 1'b1;
                     dp_cmd.out_status = dp_sts.found ? slid_pkg::ST_DELETED
                                                      : slid_pkg::ST_NOT_FOUND;
                     dp_cmd.out_last   = 1'b1;
                  end
                  slid_pkg::CMD_DUMP: begin
                     if (dp_sts.empty) begin
                        dp_cmd.load_out   = 1'b1;
                        dp_cmd.out_status = slid_pkg::ST_EMPTY;
                        dp_cmd.out_zero   = 1'b1;
                        dp_cmd.out_last   = 1'b1;
                     end else begin
                        state_in = S_DUMP;
                        idx_in   = '0;
                     end
                  end
                  default: begin
                     // unused code: drop the word
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               dp_cmd.load_out      = 1'b1;
               dp_cmd.out_status    = slid_pkg::ST_ENTRY;
               dp_cmd.out_from_cell = 1'b1;
               dp_cmd.rd_idx        = idx_ff;
               dp_cmd.out_last      = (idx_ff == dp_sts.last_idx);
               if (idx_ff == dp_sts.last_idx) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (dp_cmd.load_out) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== src/slid_dpath.sv =====
module slid_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [slid_pkg::VAL_W-1:0] req_value,
   input  slid_pkg::slid_cmd_type            dp_cmd,
   output slid_pkg::slid_sts_type            dp_sts,
   output logic [slid_pkg::STAT_W-1:0]       rsp_status,
   output logic signed [slid_pkg::VAL_W-1:0] rsp_item_value,
   output logic                              rsp_last
);

   localparam int N = slid_pkg::CAPACITY;

   logic signed [slid_pkg::VAL_W-1:0] cells_ff [N];
   logic signed [slid_pkg::VAL_W-1:0] cells_in [N];
   logic [slid_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [slid_pkg::STAT_W-1:0]       status_ff;
   logic signed [slid_pkg::VAL_W-1:0] value_ff, value_in;
   logic                              last_ff;

   logic [N-1:0] lt;
   logic [N-1:0] hit;
   logic [N-1:0] hit_upto;

   // per-cell compares against the request value
   always_comb begin
      for (int i = 0; i < N; i++) begin
         lt[i]  = (slid_pkg::CNT_W'(i) < count_ff) && (cells_ff[i] < req_value);
         hit[i] = (slid_pkg::CNT_W'(i) < count_ff) && (cells_ff[i] == req_value);
      end
      hit_upto[0] = hit[0];
      for (int i = 1; i < N; i++) begin
         hit_upto[i] = hit_upto[i-1] | hit[i];
      end
   end

   always_comb begin
      dp_sts.full     = (count_ff == slid_pkg::CNT_W'(N));
      dp_sts.empty    = (count_ff == '0);
      dp_sts.found    = hit_upto[N-1];
      dp_sts.count    = count_ff;
      dp_sts.last_idx = slid_pkg::IDX_W'(count_ff - 1'b1);
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         cells_in[i] = cells_ff[i];
      end
      count_in = count_ff;

      if (dp_cmd.do_insert) begin
         // cells at and above the slot move up one
         if (!lt[0]) begin
            cells_in[0] = req_value;
         end
         for (int i = 1; i < N; i++) begin
            if (!lt[i]) begin
               cells_in[i] = lt[i-1] ? req_value : cells_ff[i-1];
            end
         end
         count_in = count_ff + 1'b1;
      end else if (dp_cmd.do_delete && hit_upto[N-1]) begin
         // cells from the first match on move down one
         for (int i = 0; i < N - 1; i++) begin
            if (hit_upto[i]) begin
               cells_in[i] = cells_ff[i+1];
            end
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      if (dp_cmd.out_from_cell) begin
         value_in = cells_ff[dp_cmd.rd_idx];
      end else if (dp_cmd.out_zero) begin
         value_in = '0;
      end else begin
         value_in = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      if (dp_cmd.load_out) begin
         status_ff <= dp_cmd.out_status;
         value_ff  <= value_in;
         last_ff   <= dp_cmd.out_last;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_item_value = value_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== src/sorted_list_insert_delete.sv =====
// channel | dir | words                         | handshake
// req     | in  | cmd, value                    | valid/ready, taken when both high
// rsp     | out | status, item_value, last      | valid/ready, taken when both high
//
// Insert and delete compare all cells in parallel and shift in the same cycle;
// unused codes are dropped unanswered. A dump spends its accept cycle loading
// the read index, then sends each stored entry in turn through the output
// register; other results appear in the cycle after acceptance.
// Synchronous reset empties the list and drops any pending word; no sweep.
// A stalled rsp holds the output register and blocks req until it drains.
module sorted_list_insert_delete (
   input logic        clock,
   input logic        reset,
   slid_req_if.sink   req,
   slid_rsp_if.source rsp
);

   slid_pkg::slid_cmd_type dp_cmd;
   slid_pkg::slid_sts_type dp_sts;

   slid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .dp_sts    (dp_sts),
      .dp_cmd    (dp_cmd)
   );

   slid_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req.value),
      .dp_cmd         (dp_cmd),
      .dp_sts         (dp_sts),
      .rsp_status     (rsp.status),
      .rsp_item_value (rsp.item_value),
      .rsp_last       (rsp.last)
   );

   assert property (@(posedge clock) disable iff (reset)
      dp_cmd.do_insert |-> !dp_sts.full)
      else $error("insert into a full list");

   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.cmd == slid_pkg::CMD_INSERT) |=>
         (rsp.valid && rsp.last &&
          (rsp.status == slid_pkg::ST_INSERTED || rsp.status == slid_pkg::ST_FULL)))
      else $error("insert did not answer");

   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.cmd == slid_pkg::CMD_DELETE && !dp_sts.found) |=>
         (dp_sts.count == $past(dp_sts.count)))
      else $error("failed delete changed the count");

   assert property (@(posedge clock) disable iff (reset)
      dp_sts.count <= slid_pkg::CNT_W'(slid_pkg::CAPACITY))
      else $error("count beyond capacity");

endmodule
